// ===== rtl/core/qrs_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Quadratic root solver package
// Shared widths, codes and request/response types of the root solver.
// ---------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_W   = 16;
    localparam int ROOT_W   = 32;
    localparam int TOL_W    = 34;
    localparam int DISC_W   = 34;
    localparam int SQ_IN_W  = 50;
    localparam int SQ_STEPS = SQ_IN_W / 2;
    localparam int SQ_ROOT_W = SQ_STEPS;
    localparam int SQ_REM_W = SQ_ROOT_W + 3;
    localparam int SNUM_W   = 36;
    localparam int NUM_W    = 35;
    localparam int DEN_W    = 18;
    localparam int LANES    = 2;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(655);

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_ONE  = 2'd1;
    localparam logic [1:0] KIND_TWO  = 2'd2;
    localparam logic [1:0] KIND_INF  = 2'd3;

    typedef enum logic [2:0] {
        CL_NONE,
        CL_INF,
        CL_LINEAR,
        CL_SINGLE,
        CL_TWO
    } cls_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
    } req_t;

    typedef struct packed {
        logic [1:0]               solution_kind;
        logic signed [ROOT_W-1:0] root_one;
        logic signed [ROOT_W-1:0] root_two;
        logic                     saturated;
    } rsp_t;

    typedef struct packed {
        cls_t                     cls;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
    } sq_side_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             neg;
    } lane_t;

endpackage
`default_nettype wire

// ===== rtl/core/qrs_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Root solver front end
// Registers the request, forms b*b and a*c, then the discriminant and the
// solution class, and prepares the square root operand.
// ---------------------------------------------------------------------------
module qrs_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             en,
    input  wire logic [qrs_pkg::TOL_W-1:0]        tol,
    input  wire logic                             in_valid,
    input  wire qrs_pkg::req_t                    in_req,
    output logic                                  out_valid,
    output qrs_pkg::sq_side_t                     out_side,
    output logic [qrs_pkg::SQ_IN_W-1:0]           out_op
);

    localparam int CW = qrs_pkg::COEF_W;
    localparam int DW = qrs_pkg::DISC_W;
    localparam int TW = qrs_pkg::TOL_W;
    localparam int IW = qrs_pkg::SQ_IN_W;

    logic                   v0_reg;
    logic                   v1_reg;
    logic                   v2_reg;
    logic signed [CW-1:0]   a0_reg;
    logic signed [CW-1:0]   b0_reg;
    logic signed [CW-1:0]   c0_reg;
    logic signed [CW-1:0]   a1_reg;
    logic signed [CW-1:0]   b1_reg;
    logic signed [CW-1:0]   c1_reg;
    logic signed [2*CW-1:0] bb1_reg;
    logic signed [2*CW-1:0] ac1_reg;
    qrs_pkg::sq_side_t      side2_reg;
    logic [IW-1:0]          op2_reg;

    logic signed [DW-1:0]   disc;
    logic signed [TW+1:0]   disc_x;
    logic signed [TW+1:0]   tol_x;
    logic                   band;
    logic                   above;
    qrs_pkg::cls_t          cls_next;
    logic [IW-1:0]          op_next;

    always_comb
    begin
        disc   = DW'(bb1_reg) - (DW'(ac1_reg) <<< 2);
        disc_x = (TW+2)'(disc);
        tol_x  = $signed({2'b00, tol});
        band   = (disc_x < tol_x) && (disc_x > -tol_x);
        above  = disc_x >= tol_x;
        if (a1_reg == '0)
        begin
            if (b1_reg != '0)
                cls_next = qrs_pkg::CL_LINEAR;
            else if (c1_reg == '0)
                cls_next = qrs_pkg::CL_INF;
            else
                cls_next = qrs_pkg::CL_NONE;
        end
        else if (band)
            cls_next = qrs_pkg::CL_SINGLE;
        else if (above)
            cls_next = qrs_pkg::CL_TWO;
        else
            cls_next = qrs_pkg::CL_NONE;
        if (cls_next == qrs_pkg::CL_TWO)
            op_next = {1'b0, disc[DW-2:0], 16'b0};
        else
            op_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg        <= in_req.coef_a;
            b0_reg        <= in_req.coef_b;
            c0_reg        <= in_req.coef_c;
            a1_reg        <= a0_reg;
            b1_reg        <= b0_reg;
            c1_reg        <= c0_reg;
            bb1_reg       <= b0_reg * b0_reg;
            ac1_reg       <= a0_reg * c0_reg;
            side2_reg.cls <= cls_next;
            side2_reg.a   <= a1_reg;
            side2_reg.b   <= b1_reg;
            side2_reg.c   <= c1_reg;
            op2_reg       <= op_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_side  = side2_reg;
    assign out_op    = op2_reg;

endmodule
`default_nettype wire

// ===== rtl/core/qrs_sqrt.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Root solver square root pipeline
// Restoring integer square root, one result bit per register stage, with
// the request sideband carried alongside.
// ---------------------------------------------------------------------------
module qrs_sqrt (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             en,
    input  wire logic                             in_valid,
    input  wire qrs_pkg::sq_side_t                in_side,
    input  wire logic [qrs_pkg::SQ_IN_W-1:0]      in_op,
    output logic                                  out_valid,
    output qrs_pkg::sq_side_t                     out_side,
    output logic [qrs_pkg::SQ_ROOT_W-1:0]         out_root
);

    localparam int IW = qrs_pkg::SQ_IN_W;
    localparam int NS = qrs_pkg::SQ_STEPS;
    localparam int RW = qrs_pkg::SQ_ROOT_W;
    localparam int MW = qrs_pkg::SQ_REM_W;

    logic              valid_reg [NS];
    qrs_pkg::sq_side_t side_reg  [NS];
    logic [IW-1:0]     op_reg    [NS];
    logic [MW-1:0]     rem_reg   [NS];
    logic [RW-1:0]     root_reg  [NS];

    for (genvar k = 0; k < NS; k++)
    begin : g_step
        logic              v_in;
        qrs_pkg::sq_side_t side_in;
        logic [IW-1:0]     op_in;
        logic [MW-1:0]     rem_in;
        logic [RW-1:0]     root_in;
        logic [MW-1:0]     rem_sh;
        logic [MW-1:0]     trial;
        logic              fit;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign side_in = in_side;
            assign op_in   = in_op;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign v_in    = valid_reg[k-1];
            assign side_in = side_reg[k-1];
            assign op_in   = op_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        assign rem_sh = {rem_in[MW-3:0], op_in[IW-1 -: 2]};
        assign trial  = {{(MW-RW-2){1'b0}}, root_in, 2'b01};
        assign fit    = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_in;
                op_reg[k]   <= op_in << 2;
                rem_reg[k]  <= fit ? (rem_sh - trial) : rem_sh;
                root_reg[k] <= {root_in[RW-2:0], fit};
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_side  = side_reg[NS-1];
    assign out_root  = root_reg[NS-1];

endmodule
`default_nettype wire

// ===== rtl/core/qrs_prep.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Root solver division setup
// Builds the signed numerators and denominator for each root, then the
// rounding dividend, doubled divisor and sign of each quotient.
// ---------------------------------------------------------------------------
module qrs_prep (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  en,
    input  wire logic                                  in_valid,
    input  wire qrs_pkg::sq_side_t                     in_side,
    input  wire logic [qrs_pkg::SQ_ROOT_W-1:0]         in_root,
    output logic                                       out_valid,
    output qrs_pkg::cls_t                              out_cls,
    output qrs_pkg::lane_t [qrs_pkg::LANES-1:0]        out_lane
);

    localparam int SW = qrs_pkg::SNUM_W;
    localparam int NW = qrs_pkg::NUM_W;
    localparam int DW = qrs_pkg::DEN_W;
    localparam int NL = qrs_pkg::LANES;

    logic                 v1_reg;
    logic                 v2_reg;
    qrs_pkg::cls_t        cls1_reg;
    qrs_pkg::cls_t        cls2_reg;
    logic signed [SW-1:0] num1_reg [NL];
    logic signed [DW-1:0] den1_reg;
    qrs_pkg::lane_t       lane2_reg [NL];

    logic signed [SW-1:0] bx;
    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] num_next [NL];
    logic signed [DW-1:0] den_next;
    logic [DW-1:0]        dabs;
    logic [SW-1:0]        nabs [NL];
    qrs_pkg::lane_t       lane_next [NL];

    always_comb
    begin
        bx = SW'(in_side.b);
        sx = $signed(SW'(in_root));
        for (int l = 0; l < NL; l++)
            num_next[l] = '0;
        den_next = '0;
        case (in_side.cls)
            qrs_pkg::CL_TWO:
            begin
                num_next[0] = (sx - (bx <<< 8)) <<< 7;
                num_next[1] = (-(bx <<< 8) - sx) <<< 7;
                den_next    = DW'(in_side.a);
            end
            qrs_pkg::CL_LINEAR:
            begin
                num_next[0] = -(SW'(in_side.c) <<< 16);
                den_next    = DW'(in_side.b);
            end
            qrs_pkg::CL_SINGLE:
            begin
                num_next[0] = -(bx <<< 16);
                den_next    = DW'(in_side.a) <<< 1;
            end
            default:
            begin
                den_next = '0;
            end
        endcase
    end

    always_comb
    begin
        dabs = den1_reg[DW-1] ? DW'(-den1_reg) : DW'(den1_reg);
        for (int l = 0; l < NL; l++)
        begin
            nabs[l] = num1_reg[l][SW-1] ? SW'(-num1_reg[l]) : SW'(num1_reg[l]);
            lane_next[l].num = NW'({nabs[l], 1'b0}) + NW'(dabs);
            lane_next[l].den = DW'({dabs, 1'b0});
            lane_next[l].neg = num1_reg[l][SW-1] ^ den1_reg[DW-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cls1_reg <= in_side.cls;
            cls2_reg <= cls1_reg;
            den1_reg <= den_next;
            for (int l = 0; l < NL; l++)
            begin
                num1_reg[l]  <= num_next[l];
                lane2_reg[l] <= lane_next[l];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < NL; l++)
            out_lane[l] = lane2_reg[l];
    end

    assign out_valid = v2_reg;
    assign out_cls   = cls2_reg;

endmodule
`default_nettype wire

// ===== rtl/core/qrs_div.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Root solver divider pipeline
// Two-lane restoring divider, one quotient bit per register stage; the
// dividend register shifts the quotient in from the bottom.
// ---------------------------------------------------------------------------
module qrs_div (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          en,
    input  wire logic                                          in_valid,
    input  wire qrs_pkg::cls_t                                 in_cls,
    input  wire qrs_pkg::lane_t [qrs_pkg::LANES-1:0]           in_lane,
    output logic                                               out_valid,
    output qrs_pkg::cls_t                                      out_cls,
    output logic [qrs_pkg::LANES-1:0][qrs_pkg::NUM_W-1:0]      out_q,
    output logic [qrs_pkg::LANES-1:0]                          out_neg
);

    localparam int NW = qrs_pkg::NUM_W;
    localparam int DW = qrs_pkg::DEN_W;
    localparam int NL = qrs_pkg::LANES;

    logic          valid_reg [NW];
    qrs_pkg::cls_t cls_reg   [NW];
    logic [NW-1:0] nq_reg    [NL][NW];
    logic [DW-1:0] rem_reg   [NL][NW];
    logic [DW-1:0] den_reg   [NL][NW];
    logic          neg_reg   [NL][NW];

    for (genvar k = 0; k < NW; k++)
    begin : g_step
        logic          v_in;
        qrs_pkg::cls_t cls_in;

        if (k == 0)
        begin : g_first
            assign v_in   = in_valid;
            assign cls_in = in_cls;
        end
        else
        begin : g_next
            assign v_in   = valid_reg[k-1];
            assign cls_in = cls_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                cls_reg[k] <= cls_in;
        end

        for (genvar l = 0; l < NL; l++)
        begin : g_lane
            logic [NW-1:0] nq_in;
            logic [DW-1:0] rem_in;
            logic [DW-1:0] den_in;
            logic          neg_in;
            logic [DW:0]   rem_sh;
            logic [DW:0]   rem_sub;
            logic          fit;

            if (k == 0)
            begin : g_first
                assign nq_in  = in_lane[l].num;
                assign rem_in = '0;
                assign den_in = in_lane[l].den;
                assign neg_in = in_lane[l].neg;
            end
            else
            begin : g_next
                assign nq_in  = nq_reg[l][k-1];
                assign rem_in = rem_reg[l][k-1];
                assign den_in = den_reg[l][k-1];
                assign neg_in = neg_reg[l][k-1];
            end

            assign rem_sh  = {rem_in, nq_in[NW-1]};
            assign rem_sub = rem_sh - {1'b0, den_in};
            assign fit     = rem_sh >= {1'b0, den_in};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    nq_reg[l][k]  <= {nq_in[NW-2:0], fit};
                    rem_reg[l][k] <= fit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
                    den_reg[l][k] <= den_in;
                    neg_reg[l][k] <= neg_in;
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            out_q[l]   = nq_reg[l][NW-1];
            out_neg[l] = neg_reg[l][NW-1];
        end
    end

    assign out_valid = valid_reg[NW-1];
    assign out_cls   = cls_reg[NW-1];

endmodule
`default_nettype wire

// ===== rtl/core/quadratic_root_solver_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Quadratic root solver
// Solves a*x^2 + b*x + c = 0 for Q8.8 coefficients, Q16.16 roots.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel in_valid / in_stall / in_data carries coef_a, coef_b and
//   coef_c; a request is taken when in_valid is high and in_stall is low.
//   Response channel out_valid / out_stall / out_data carries the solution
//   kind, both roots and the saturation flag.
//   Write port cfg_valid / cfg_ready / cfg_data sets the discriminant
//   tolerance; cfg_ready is always high. Write it only while idle.
//   Between request and out_valid lie three front stages, 25 square root
//   stages, two setup stages, 35 divider stages and the output register.
//   Throughput is one request per cycle while in_stall is low.
//   Reset clears every valid bit and loads the tolerance with 655.
//   A stalled response holds in the output register; the next response
//   lands in a skid register, and only then does in_stall rise and the
//   whole pipeline hold.
// ---------------------------------------------------------------------------
module quadratic_root_solver_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire qrs_pkg::req_t                 in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output qrs_pkg::rsp_t                      out_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [qrs_pkg::TOL_W-1:0]     cfg_data
);

    localparam int NW = qrs_pkg::NUM_W;
    localparam int RW = qrs_pkg::ROOT_W;
    localparam int NL = qrs_pkg::LANES;
    localparam logic [NW-1:0] Q_NEG_LIM = NW'(1) << (RW - 1);
    localparam logic [NW-1:0] Q_POS_LIM = Q_NEG_LIM - NW'(1);

    logic [qrs_pkg::TOL_W-1:0]      tol_reg;
    logic                           out_valid_reg;
    qrs_pkg::rsp_t                  out_data_reg;
    logic                           skid_valid_reg;
    qrs_pkg::rsp_t                  skid_data_reg;

    logic                           en;
    logic                           fr_valid;
    qrs_pkg::sq_side_t              fr_side;
    logic [qrs_pkg::SQ_IN_W-1:0]    fr_op;
    logic                           sq_valid;
    qrs_pkg::sq_side_t              sq_side;
    logic [qrs_pkg::SQ_ROOT_W-1:0]  sq_root;
    logic                           pr_valid;
    qrs_pkg::cls_t                  pr_cls;
    qrs_pkg::lane_t [NL-1:0]        pr_lane;
    logic                           dv_valid;
    qrs_pkg::cls_t                  dv_cls;
    logic [NL-1:0][NW-1:0]          dv_q;
    logic [NL-1:0]                  dv_neg;
    logic [NL-1:0][RW:0]            fin;
    qrs_pkg::rsp_t                  rsp_next;

    function automatic logic [RW:0] sat_root(input logic [NW-1:0] q, input logic neg);
        logic [NW-1:0] lim;
        logic          sat;
        logic [RW-1:0] mag;
        lim = neg ? Q_NEG_LIM : Q_POS_LIM;
        sat = q > lim;
        mag = sat ? lim[RW-1:0] : q[RW-1:0];
        return {sat, neg ? (-mag) : mag};
    endfunction

    assign en        = !skid_valid_reg;
    assign in_stall  = skid_valid_reg;
    assign cfg_ready = 1'b1;

    qrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .tol       (tol_reg),
        .in_valid  (in_valid),
        .in_req    (in_data),
        .out_valid (fr_valid),
        .out_side  (fr_side),
        .out_op    (fr_op)
    );

    qrs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_side   (fr_side),
        .in_op     (fr_op),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_root  (sq_root)
    );

    qrs_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_side   (sq_side),
        .in_root   (sq_root),
        .out_valid (pr_valid),
        .out_cls   (pr_cls),
        .out_lane  (pr_lane)
    );

    qrs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pr_valid),
        .in_cls    (pr_cls),
        .in_lane   (pr_lane),
        .out_valid (dv_valid),
        .out_cls   (dv_cls),
        .out_q     (dv_q),
        .out_neg   (dv_neg)
    );

    always_comb
    begin
        for (int l = 0; l < NL; l++)
            fin[l] = sat_root(dv_q[l], dv_neg[l]);
        rsp_next = '0;
        case (dv_cls) inside
            qrs_pkg::CL_TWO:
            begin
                rsp_next.solution_kind = qrs_pkg::KIND_TWO;
                rsp_next.root_one      = fin[0][RW-1:0];
                rsp_next.root_two      = fin[1][RW-1:0];
                rsp_next.saturated     = fin[0][RW] | fin[1][RW];
            end
            qrs_pkg::CL_LINEAR, qrs_pkg::CL_SINGLE:
            begin
                rsp_next.solution_kind = qrs_pkg::KIND_ONE;
                rsp_next.root_one      = fin[0][RW-1:0];
                rsp_next.saturated     = fin[0][RW];
            end
            qrs_pkg::CL_INF:
            begin
                rsp_next.solution_kind = qrs_pkg::KIND_INF;
            end
            default:
            begin
                rsp_next.solution_kind = qrs_pkg::KIND_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= qrs_pkg::TOL_RESET;
        else if (cfg_valid && cfg_ready)
            tol_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (!out_stall)
                skid_valid_reg <= 1'b0;
        end
        else if (dv_valid)
        begin
            if (out_valid_reg && out_stall)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (!out_stall)
                out_data_reg <= skid_data_reg;
        end
        else if (dv_valid)
        begin
            if (out_valid_reg && out_stall)
                skid_data_reg <= rsp_next;
            else
                out_data_reg <= rsp_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !out_stall |=> !skid_valid_reg)
        else $error("skid register did not drain");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> tol_reg == $past(cfg_data))
        else $error("tolerance write lost");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg.solution_kind == qrs_pkg::KIND_NONE)
        |-> (out_data_reg.root_one == '0) && (out_data_reg.root_two == '0)
            && !out_data_reg.saturated)
        else $error("response without roots carries root data");

endmodule
`default_nettype wire

// ===== tb/sv/tb_quadratic_root_solver_unit.sv =====
// ---------------------------------------------------------------------------
// Quadratic root solver testbench
// Drives coefficient requests with random gaps and output stalls, predicts
// each response in Q16.16 arithmetic and checks responses in order, across
// several discriminant tolerance settings including the extremes.
// ---------------------------------------------------------------------------
module tb_quadratic_root_solver_unit;

    class root_scoreboard;
        logic [qrs_pkg::TOL_W-1:0] tolerance;
        qrs_pkg::rsp_t             pending[$];
        int                        errors;

        function new();
            tolerance = qrs_pkg::TOL_RESET;
            errors    = 0;
        endfunction

        function logic [63:0] isqrt(logic [63:0] v);
            logic [63:0] r;
            logic [63:0] bt;
            r  = 0;
            bt = 64'd1 << 62;
            while (bt > v)
                bt = bt >> 2;
            while (bt != 0)
            begin
                if (v >= r + bt)
                begin
                    v = v - (r + bt);
                    r = (r >> 1) + bt;
                end
                else
                    r = r >> 1;
                bt = bt >> 2;
            end
            return r;
        endfunction

        function logic [31:0] div_round(longint num, longint den, inout logic sat);
            logic [63:0] n;
            logic [63:0] d;
            logic [63:0] q;
            n = (num < 0) ? -num : num;
            d = (den < 0) ? -den : den;
            q = (2 * n + d) / (2 * d);
            if ((num < 0) != (den < 0))
            begin
                if (q > 64'h8000_0000)
                begin
                    q   = 64'h8000_0000;
                    sat = 1'b1;
                end
                return 32'(-q);
            end
            if (q > 64'h7FFF_FFFF)
            begin
                q   = 64'h7FFF_FFFF;
                sat = 1'b1;
            end
            return q[31:0];
        endfunction

        function void note_request(qrs_pkg::req_t req);
            longint        a;
            longint        b;
            longint        c;
            longint        disc;
            longint        tol;
            longint        s;
            qrs_pkg::rsp_t r;
            a = req.coef_a;
            b = req.coef_b;
            c = req.coef_c;
            r = '0;
            if (a == 0)
            begin
                if (b == 0)
                    r.solution_kind = (c == 0) ? qrs_pkg::KIND_INF : qrs_pkg::KIND_NONE;
                else
                begin
                    r.solution_kind = qrs_pkg::KIND_ONE;
                    r.root_one = div_round(-c * 65536, b, r.saturated);
                end
            end
            else
            begin
                disc = b * b - 4 * a * c;
                tol  = longint'(tolerance);
                if (disc < tol && disc > -tol)
                begin
                    r.solution_kind = qrs_pkg::KIND_ONE;
                    r.root_one = div_round(-b * 65536, 2 * a, r.saturated);
                end
                else if (disc >= tol)
                begin
                    s = longint'(isqrt(64'(disc) << 16));
                    r.solution_kind = qrs_pkg::KIND_TWO;
                    r.root_one = div_round((-256 * b + s) * 128, a, r.saturated);
                    r.root_two = div_round((-256 * b - s) * 128, a, r.saturated);
                end
                else
                    r.solution_kind = qrs_pkg::KIND_NONE;
            end
            pending.push_back(r);
        endfunction

        function void check_response(qrs_pkg::rsp_t got);
            qrs_pkg::rsp_t exp_r;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected response %p", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.solution_kind !== exp_r.solution_kind)
            begin
                $display("%0t: kind exp %0d got %0d", $time,
                         exp_r.solution_kind, got.solution_kind);
                errors++;
            end
            if (got.root_one !== exp_r.root_one)
            begin
                $display("%0t: root_one exp %h got %h", $time,
                         exp_r.root_one, got.root_one);
                errors++;
            end
            if (got.root_two !== exp_r.root_two)
            begin
                $display("%0t: root_two exp %h got %h", $time,
                         exp_r.root_two, got.root_two);
                errors++;
            end
            if (got.saturated !== exp_r.saturated)
            begin
                $display("%0t: saturated exp %b got %b", $time,
                         exp_r.saturated, got.saturated);
                errors++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    qrs_pkg::req_t             in_data;
    logic                      out_valid;
    logic                      out_stall;
    qrs_pkg::rsp_t             out_data;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [qrs_pkg::TOL_W-1:0] cfg_data;

    root_scoreboard sb;
    bit             calm;
    int             hold_off;

    quadratic_root_solver_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // output side: random stalls, plus a counted hold-off on request
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_response(out_data);
        if (hold_off > 0)
        begin
            hold_off  <= hold_off - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(99) < 18);
    end

    task automatic send_request(qrs_pkg::req_t req);
        while (!calm && ($urandom_range(99) < 18))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(req);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (80)
            @(posedge clk);
    endtask

    task automatic write_tolerance(logic [qrs_pkg::TOL_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.tolerance = v;
    endtask

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(int count);
        qrs_pkg::req_t req;
        repeat (count)
        begin
            req.coef_a = ($urandom_range(9) == 0) ? 16'h0000 : pick_coef();
            req.coef_b = pick_coef();
            req.coef_c = pick_coef();
            // aim at a double root: c = b*b / (4*a) rounded down, so b*b - 4*a*c is small
            if ($urandom_range(7) == 0)
            begin
                req.coef_a = 16'd1 << $urandom_range(3);
                req.coef_b = 16'($urandom_range(64)) << 1;
                req.coef_c = 16'(int'(req.coef_b) * int'(req.coef_b)
                                 / (4 * int'(req.coef_a)));
            end
            send_request(req);
        end
    endtask

    initial
    begin
        sb        = new();
        calm      = 1'b0;
        hold_off  = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        send_request('{16'sd0, 16'sd0, 16'sd0});
        send_request('{16'sd0, 16'sd0, 16'sd256});
        send_request('{16'sd0, 16'sd256, -16'sd512});
        send_request('{16'sd0, 16'sd1, -16'sd32768});
        send_request('{16'sd0, -16'sd1, -16'sd32768});
        send_request('{16'sd256, -16'sd512, 16'sd256});
        send_request('{16'sd256, 16'sd0, -16'sd256});
        send_request('{16'sd256, 16'sd0, 16'sd256});
        send_request('{16'sd1, -16'sd32768, 16'sd0});
        send_request('{-16'sd32768, -16'sd32768, 16'sd32767});
        send_request('{16'sd32767, 16'sd32767, -16'sd32768});
        send_request('{16'sd1, 16'sd32767, 16'sd1});
        drain();

        // discriminant exactly at +/- tolerance: b*b - 4ac = +4 or -4
        write_tolerance(34'd4);
        send_request('{16'sd1, 16'sd2, 16'sd0});
        send_request('{16'sd1, 16'sd0, 16'sd1});
        send_request('{-16'sd1, 16'sd0, 16'sd1});
        drain();
        write_tolerance(34'd0);
        send_request('{16'sd256, -16'sd512, 16'sd256});
        send_request('{16'sd1, 16'sd2, 16'sd1});
        drain();

        write_tolerance(qrs_pkg::TOL_RESET);
        random_phase(150);
        // long receiver hold-off while requests keep coming
        hold_off = 300;
        random_phase(100);
        drain();

        write_tolerance(34'h3_FFFF_FFFF);
        random_phase(60);
        drain();
        write_tolerance(34'd0);
        random_phase(60);
        drain();
        calm = 1'b1;
        write_tolerance(34'($urandom_range(100000)));
        random_phase(60);
        calm = 1'b0;
        random_phase(60);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/qrs_pkg.sv
rtl/core/qrs_front.sv
rtl/core/qrs_sqrt.sv
rtl/core/qrs_prep.sv
rtl/core/qrs_div.sv
rtl/core/quadratic_root_solver_unit.sv
tb/sv/tb_quadratic_root_solver_unit.sv
